>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the bitmap scan engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds in the same cycle as its condition.
`define BSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap scan engine: same-cycle check failed");

// Check that holds in the cycle after its condition.
`define BSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap scan engine: next-cycle check failed");

`endif

>>> rtl/core/bse_pkg.sv
// Shared types and constants of the bitmap scan engine.
`default_nettype none
package bse_pkg;

    localparam int MAX_WORDS = 32;
    localparam int WORD_W    = 32;
    localparam int WIDX_W    = 5;
    localparam int BIT_W     = 10;
    localparam int CNT_W     = 11;
    localparam int USED_W    = 6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Byte address bit that selects the register; only register 0 exists.
    localparam logic REG_WORDS_IN_USE = 1'b0;
    localparam logic [USED_W-1:0] WORDS_IN_USE_RESET = 6'd32;

    typedef struct packed {
        logic load_en;
        logic query_start;
        logic scan_rd;
        logic result_load;
    } bse_cmd_t;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic last_addr;
        logic out_busy;
    } bse_status_t;

endpackage
`default_nettype wire

>>> rtl/core/bse_if.sv
// Valid/ready channel interfaces for the query words and the result words.
`default_nettype none
interface bse_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [bse_pkg::WIDX_W-1:0]   word_index;
    logic [bse_pkg::WORD_W-1:0]   word_value;
    logic [bse_pkg::BIT_W-1:0]    from_bit;

    modport source (output valid, cmd, word_index, word_value, from_bit, input ready);
    modport sink   (input valid, cmd, word_index, word_value, from_bit, output ready);
endinterface

interface bse_out_if;
    logic                         valid;
    logic                         ready;
    logic [bse_pkg::CNT_W-1:0]    set_count;
    logic [bse_pkg::CNT_W-1:0]    run_length;
    logic [bse_pkg::BIT_W-1:0]    next_set;
    logic                         next_found;

    modport source (output valid, set_count, run_length, next_set, next_found, input ready);
    modport sink   (input valid, set_count, run_length, next_set, next_found, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bitmap_scan_engine_top.sv
// Top level of the bitmap scan engine: channels, register port and core wiring.
//
// Usage: the query channel carries one word per command. A load (cmd 0) writes
// word_value into bitmap word word_index and gives no result; loads are taken
// one per cycle while the engine is idle. A query (cmd 1) scans the bitmap from
// from_bit to the end of the used words and returns one result word with the
// count of set bits, the length of the run of set bits at from_bit and the first
// set bit at or after from_bit. The scan reads the words from the start word to
// the last used word (at most 32) one per cycle from the bitmap memory; the last
// word read is folded into the totals in a flush state and the totals are then
// loaded into the output register. A start at or past the end of the used bitmap
// skips the scan. The next word is taken only once the result is loaded, so a
// new query is not accepted before the last one is through.
// The result sits in an output register: a stalled receiver does not block the
// acceptance of loads or of the next query until that query needs the register.
// Reset clears the control logic and sets words_in_use to 32; bitmap words are
// undefined until loaded. words_in_use lives at byte address 0 of the APB port;
// the user must write it only while the engine is idle; no logic enforces it.
`default_nettype none
module bitmap_scan_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    bse_in_if.sink      query,
    bse_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bse_pkg::*;

    logic [USED_W-1:0] words_in_use_reg;
    bse_cmd_t          cmd;
    bse_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= WORDS_IN_USE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WORDS_IN_USE))
        begin
            words_in_use_reg <= pwdata[USED_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_WORDS_IN_USE) ? {26'b0, words_in_use_reg} : 32'b0;

    bse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (query.valid),
        .in_ready (query.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bse_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_cmd         (query.cmd),
        .in_word_index  (query.word_index),
        .in_word_value  (query.word_value),
        .in_from_bit    (query.from_bit),
        .words_in_use   (words_in_use_reg),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_set_count  (result.set_count),
        .out_run_length (result.run_length),
        .out_next_set   (result.next_set),
        .out_next_found (result.next_found)
    );

endmodule
`default_nettype wire

>>> rtl/core/bse_ctrl.sv
// Controller state machine that sequences loads, word scans and result hand-off.
`default_nettype none
module bse_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bse_pkg::bse_status_t status,
    output bse_pkg::bse_cmd_t    cmd
);
    import bse_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!status.is_query)
                    begin
                        cmd.load_en = 1'b1;
                    end
                    else
                    begin
                        cmd.query_start = 1'b1;
                        state_next = status.empty ? ST_OUT : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // The last word read is folded into the totals in this cycle.
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/bse_dp.sv
// Datapath: bitmap memory, word scan accumulators and the result register.
`default_nettype none
module bse_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bse_pkg::bse_cmd_t             cmd,
    output bse_pkg::bse_status_t          status,
    input  logic                          in_cmd,
    input  logic [bse_pkg::WIDX_W-1:0]    in_word_index,
    input  logic [bse_pkg::WORD_W-1:0]    in_word_value,
    input  logic [bse_pkg::BIT_W-1:0]     in_from_bit,
    input  logic [bse_pkg::USED_W-1:0]    words_in_use,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bse_pkg::CNT_W-1:0]     out_set_count,
    output logic [bse_pkg::CNT_W-1:0]     out_run_length,
    output logic [bse_pkg::BIT_W-1:0]     out_next_set,
    output logic                          out_next_found
);
    import bse_pkg::*;

    localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_WORDS);

    function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] v);
        logic [5:0] sum;
        sum = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            sum = sum + {5'b0, v[i]};
        end
        return sum;
    endfunction

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [4:0] ctz32(input logic [WORD_W-1:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    logic [WORD_W-1:0] mem [MAX_WORDS];

    logic [WIDX_W-1:0] addr_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [WIDX_W-1:0] rd_word_reg;
    logic              rd_first_reg;
    logic              first_pending_reg;
    logic [4:0]        start_off_reg;
    logic [USED_W-1:0] used_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  run_reg;
    logic              in_run_reg;
    logic              found_reg;
    logic [BIT_W-1:0]  next_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [CNT_W-1:0]  out_run_reg;
    logic [BIT_W-1:0]  out_next_reg;
    logic              out_found_reg;

    logic [USED_W-1:0] used_in;
    logic [CNT_W-1:0]  end_bit;
    logic [4:0]        off;
    logic [WORD_W-1:0] hi_mask;
    logic [WORD_W-1:0] set_bits;
    logic [WORD_W-1:0] clear_bits;
    logic [4:0]        set_pos;
    logic [4:0]        clear_pos;
    logic [5:0]        span;

    assign used_in = (words_in_use > USED_MAX) ? USED_MAX : words_in_use;
    assign end_bit = {used_in, 5'b0};

    assign status.is_query  = (in_cmd == CMD_QUERY);
    assign status.empty     = ({1'b0, in_from_bit} >= end_bit);
    assign status.last_addr = ({1'b0, addr_reg} == (used_reg - 6'd1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Only the first word of a scan is cut below the start bit.
    assign off        = rd_first_reg ? start_off_reg : 5'd0;
    assign hi_mask    = {WORD_W{1'b1}} << off;
    assign set_bits   = rd_data_reg & hi_mask;
    assign clear_bits = ~rd_data_reg & hi_mask;
    assign set_pos    = ctz32(set_bits);
    assign clear_pos  = ctz32(clear_bits);
    assign span       = 6'd32 - {1'b0, off};

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            mem[in_word_index] <= in_word_value;
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            addr_reg          <= in_from_bit[BIT_W-1:5];
            start_off_reg     <= in_from_bit[4:0];
            used_reg          <= used_in;
            first_pending_reg <= 1'b1;
            count_reg         <= '0;
            run_reg           <= '0;
            in_run_reg        <= 1'b1;
            found_reg         <= 1'b0;
            next_reg          <= '0;
        end
        else
        begin
            if (cmd.scan_rd)
            begin
                addr_reg          <= addr_reg + 5'd1;
                rd_word_reg       <= addr_reg;
                rd_first_reg      <= first_pending_reg;
                first_pending_reg <= 1'b0;
            end
            if (rd_valid_reg)
            begin
                count_reg <= count_reg + {5'b0, popcount32(set_bits)};
                if (in_run_reg)
                begin
                    if (clear_bits == '0)
                    begin
                        run_reg <= run_reg + {5'b0, span};
                    end
                    else
                    begin
                        run_reg    <= run_reg + {6'b0, clear_pos - off};
                        in_run_reg <= 1'b0;
                    end
                end
                if (!found_reg && (set_bits != '0))
                begin
                    found_reg <= 1'b1;
                    next_reg  <= {rd_word_reg, set_pos};
                end
            end
        end
        if (cmd.result_load)
        begin
            out_count_reg <= count_reg;
            out_run_reg   <= run_reg;
            out_next_reg  <= next_reg;
            out_found_reg <= found_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_set_count  = out_count_reg;
    assign out_run_length = out_run_reg;
    assign out_next_set   = out_next_reg;
    assign out_next_found = out_found_reg;

endmodule
`default_nettype wire

>>> rtl/core/bse_checker.sv
// Port-level checker of the bitmap scan engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module bse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       q_valid,
    input logic                       q_ready,
    input logic                       q_cmd,
    input logic                       r_valid,
    input logic                       r_ready,
    input logic [bse_pkg::CNT_W-1:0]  set_count,
    input logic [bse_pkg::CNT_W-1:0]  run_length,
    input logic [bse_pkg::BIT_W-1:0]  next_set,
    input logic                       next_found
);
    import bse_pkg::*;

    logic [2*CNT_W+BIT_W:0] r_payload;
    logic                   r_all_zero;

    assign r_payload  = {set_count, run_length, next_set, next_found};
    assign r_all_zero = (next_set == 10'd0) && (set_count == 11'd0) && (run_length == 11'd0);

    `BSE_ASSERT_NEXT(a_result_held, r_valid && !r_ready, r_valid && $stable(r_payload))
    `BSE_ASSERT_SAME(a_not_found_empty, r_valid && !next_found, r_all_zero)
    `BSE_ASSERT_SAME(a_run_within_count, r_valid, run_length <= set_count)
    `BSE_ASSERT_NEXT(a_busy_after_query, q_valid && q_ready && (q_cmd == CMD_QUERY), !q_ready)

endmodule

bind bitmap_scan_engine_top bse_checker u_bse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (query.valid),
    .q_ready    (query.ready),
    .q_cmd      (query.cmd),
    .r_valid    (result.valid),
    .r_ready    (result.ready),
    .set_count  (result.set_count),
    .run_length (result.run_length),
    .next_set   (result.next_set),
    .next_found (result.next_found)
);
`default_nettype wire
